// ===== hdl/midpoint_circle_rasterizer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the midpoint circle rasterizer
// Clocked concurrent assertions with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

// Assertion that is switched off while the reset is high.
`define MCR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("midpoint_circle_rasterizer: assertion failed");

// Assertion that is checked at every edge, reset included.
`define MCR_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("midpoint_circle_rasterizer: reset assertion failed");

`endif

// ===== hdl/mcr_pkg.sv =====
// ---------------------------------------------------------------------------
// mcr_pkg
// Shared constants, types and width helpers of the circle rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

   // Width of an output pixel coordinate (two's complement).
   localparam int PIXEL_BITS = 12;

   // Point index within one group of eight symmetric points.
   localparam int PT_IDX_BITS = 3;
   localparam logic [PT_IDX_BITS-1:0] LAST_POINT_IDX = 3'd7;

   // Request codes.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // How one point of the group is formed from the octant point.
   typedef struct packed {
      logic swap;    // use (y, x) instead of (x, y)
      logic neg_x;   // subtract the x term from the centre
      logic neg_y;   // subtract the y term from the centre
   } point_sel_type;

   function automatic point_sel_type point_sel(input logic [PT_IDX_BITS-1:0] idx);
      point_sel_type sel;
      sel.swap  = idx[2];
      sel.neg_x = idx[1];
      sel.neg_y = idx[0];
      return sel;
   endfunction

   // Signed width of the octant coordinates (they run from -1 to radius + 1).
   function automatic int xy_bits(input int radius_bits);
      return radius_bits + 2;
   endfunction

   // Signed width of the decision value.
   function automatic int dec_bits(input int radius_bits);
      return radius_bits + 5;
   endfunction

   // Width of one queued group: centre x, centre y, x, y, done flag.
   function automatic int job_bits(input int coord_bits, input int radius_bits);
      return 2 * coord_bits + 2 * xy_bits(radius_bits) + 1;
   endfunction

   // Width of the pixel adder, wide enough for every operand plus a carry.
   function automatic int sum_bits(input int coord_bits, input int radius_bits);
      int w;
      w = coord_bits + 1;
      if (xy_bits(radius_bits) > w) begin
         w = xy_bits(radius_bits);
      end
      if (PIXEL_BITS > w) begin
         w = PIXEL_BITS;
      end
      return w + 1;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mcr_if.sv =====
// ---------------------------------------------------------------------------
// mcr_req_if / mcr_rsp_if
// Valid/ready channels for request words and pixel words.
// ---------------------------------------------------------------------------
`default_nettype none

interface mcr_req_if #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 9
);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0] radius;

   modport source (output valid, req_type, center_x, center_y, radius, input ready);
   modport sink   (input valid, req_type, center_x, center_y, radius, output ready);
endinterface

interface mcr_rsp_if;
   import mcr_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel_x;
   logic signed [PIXEL_BITS-1:0] pixel_y;
   logic                         last_point;
   logic                         circle_done;

   modport source (output valid, pixel_x, pixel_y, last_point, circle_done, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_point, circle_done, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcr_front.sv =====
// ---------------------------------------------------------------------------
// mcr_front
// Takes request words, keeps the octant walk and queues one group per start word or running step word.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_front #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 9
) (
   input  logic clock,
   input  logic reset,
   mcr_req_if.sink req_chan,
   output logic job_valid,
   input  logic job_ready,
   output logic [mcr_pkg::job_bits(COORD_BITS, RADIUS_BITS)-1:0] job_data
);
   import mcr_pkg::*;

   localparam int XY_W = xy_bits(RADIUS_BITS);
   localparam int D_W  = dec_bits(RADIUS_BITS);

   localparam logic signed [XY_W-1:0] XY_ONE  = XY_W'(1);
   localparam logic signed [D_W-1:0]  D_THREE = D_W'(3);
   localparam logic signed [D_W-1:0]  D_SIX   = D_W'(6);
   localparam logic signed [D_W-1:0]  D_TEN   = D_W'(10);

   logic [COORD_BITS-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [XY_W-1:0]  x_step, y_step, y_dec, diff;
   logic signed [D_W-1:0]   d_ff, d_in, d_step, d_start;
   logic [D_W-1:0]          x_ext, diff_ext, r_ext;
   logic                    running_ff, running_in;
   logic                    accept, emit, done, step_done, d_le_zero;

   assign req_chan.ready = job_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // One step of the walk, computed from the current state.
   always_comb begin
      x_step    = x_ff + XY_ONE;
      y_dec     = y_ff - XY_ONE;
      diff      = x_step - y_dec;
      x_ext     = {{(D_W-XY_W){x_step[XY_W-1]}}, x_step};
      diff_ext  = {{(D_W-XY_W){diff[XY_W-1]}}, diff};
      d_le_zero = d_ff[D_W-1] || (d_ff == '0);
      if (d_le_zero) begin
         y_step = y_ff;
         d_step = d_ff + signed'(x_ext << 2) + D_SIX;
      end else begin
         y_step = y_dec;
         d_step = d_ff + signed'(diff_ext << 2) + D_TEN;
      end
      step_done = x_step > y_step;
      r_ext     = {{(D_W-RADIUS_BITS){1'b0}}, req_chan.radius};
      d_start   = D_THREE - signed'(r_ext << 1);
   end

   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      d_in       = d_ff;
      running_in = running_ff;
      emit       = 1'b0;
      done       = 1'b0;
      if (accept) begin
         case (req_chan.req_type)
            REQ_START: begin
               cx_in      = req_chan.center_x;
               cy_in      = req_chan.center_y;
               x_in       = '0;
               y_in       = {{(XY_W-RADIUS_BITS){1'b0}}, req_chan.radius};
               d_in       = d_start;
               running_in = 1'b1;
               emit       = 1'b1;
            end
            REQ_STEP: begin
               // A running circle always has x <= y, so only the flag is tested.
               if (running_ff) begin
                  x_in       = x_step;
                  y_in       = y_step;
                  d_in       = d_step;
                  running_in = !step_done;
                  emit       = 1'b1;
                  done       = step_done;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   assign job_valid = emit;
   assign job_data  = {cx_in, cy_in, x_in, y_in, done};

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff      <= '0;
         cy_ff      <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         d_ff       <= '0;
         running_ff <= 1'b0;
      end else begin
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         d_ff       <= d_in;
         running_ff <= running_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mcr_queue.sv =====
// ---------------------------------------------------------------------------
// mcr_queue
// Two-entry queue of point groups between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_queue #(
   parameter int WIDTH = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import mcr_pkg::*;

   localparam logic [1:0] FULL_COUNT = 2'd2;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != FULL_COUNT;
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mcr_back.sv =====
// ---------------------------------------------------------------------------
// mcr_back
// Expands one queued group into eight pixel words through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_back #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 9
) (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  logic [mcr_pkg::job_bits(COORD_BITS, RADIUS_BITS)-1:0] job_data,
   mcr_rsp_if.source rsp_chan
);
   import mcr_pkg::*;

   localparam int XY_W  = xy_bits(RADIUS_BITS);
   localparam int SUM_W = sum_bits(COORD_BITS, RADIUS_BITS);
   localparam int JOB_W = job_bits(COORD_BITS, RADIUS_BITS);

   logic [COORD_BITS-1:0]         job_cx, job_cy;
   logic [XY_W-1:0]               job_x, job_y, term_a, term_b;
   logic                          job_done;
   point_sel_type                 sel;
   logic [SUM_W-1:0]              cx_ext, cy_ext, a_ext, b_ext, sum_x, sum_y;
   logic [PT_IDX_BITS-1:0]        pt_ff, pt_in;
   logic                          valid_ff, valid_in, load;
   logic signed [PIXEL_BITS-1:0]  px_ff, py_ff;
   logic                          last_ff, done_ff;

   assign job_cx   = job_data[JOB_W-1 -: COORD_BITS];
   assign job_cy   = job_data[JOB_W-1-COORD_BITS -: COORD_BITS];
   assign job_x    = job_data[2*XY_W -: XY_W];
   assign job_y    = job_data[XY_W -: XY_W];
   assign job_done = job_data[0];

   assign load = job_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      sel    = point_sel(pt_ff);
      term_a = sel.swap ? job_y : job_x;
      term_b = sel.swap ? job_x : job_y;
      cx_ext = {{(SUM_W-COORD_BITS){1'b0}}, job_cx};
      cy_ext = {{(SUM_W-COORD_BITS){1'b0}}, job_cy};
      a_ext  = {{(SUM_W-XY_W){term_a[XY_W-1]}}, term_a};
      b_ext  = {{(SUM_W-XY_W){term_b[XY_W-1]}}, term_b};
      sum_x  = sel.neg_x ? cx_ext - a_ext : cx_ext + a_ext;
      sum_y  = sel.neg_y ? cy_ext - b_ext : cy_ext + b_ext;
   end

   always_comb begin
      pt_in     = load ? pt_ff + PT_IDX_BITS'(1) : pt_ff;
      job_ready = load && (pt_ff == LAST_POINT_IDX);
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff   <= sum_x[PIXEL_BITS-1:0];
         py_ff   <= sum_y[PIXEL_BITS-1:0];
         last_ff <= pt_ff == LAST_POINT_IDX;
         done_ff <= job_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pt_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         pt_ff    <= pt_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.pixel_x     = px_ff;
   assign rsp_chan.pixel_y     = py_ff;
   assign rsp_chan.last_point  = last_ff;
   assign rsp_chan.circle_done = done_ff;

endmodule

`default_nettype wire

// ===== hdl/midpoint_circle_rasterizer.sv =====
// ---------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle generator that emits the eight symmetric points of each step.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  --------  ---------  ---------------------------------------------------
//  req_chan  in         req_type, center_x, center_y, radius
//  rsp_chan  out        pixel_x, pixel_y, last_point, circle_done
//
// A start word or a step word of a running circle produces eight pixel words,
// one per cycle while the output is not stalled, through the single output register.
// A step word with no circle running produces nothing and takes no queue entry.
// Request words are taken while the two-entry group queue has room, so the
// front runs up to three words ahead of the pixel stream.
// Reset is synchronous; it stops the circle and empties the queue and the
// output register. A stalled pixel word holds until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 9
) (
   input  logic clock,
   input  logic reset,
   mcr_req_if.sink   req_chan,
   mcr_rsp_if.source rsp_chan
);
   import mcr_pkg::*;

   localparam int JOB_W = job_bits(COORD_BITS, RADIUS_BITS);

   // Groups leave the front as the centre, the octant point after the word's
   // update, and the flag that says whether the walk has now finished.
   logic             fq_valid, fq_ready;
   logic [JOB_W-1:0] fq_data;
   logic             qb_valid, qb_ready;
   logic [JOB_W-1:0] qb_data;

   // The front holds the walk state and the decision value. It updates them
   // in the cycle a word is taken, independent of how far the back lags.
   mcr_front #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   // The queue lets the front keep taking words while the back is busy.
   mcr_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // The back walks a three-bit point index over the queue head and releases
   // the entry when the eighth point enters the output register.
   mcr_back #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hdl/mcr_checker.sv =====
// ---------------------------------------------------------------------------
// mcr_checker
// Port-level checks of the pixel stream, bound to the rasterizer top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "midpoint_circle_rasterizer_assert.svh"

module mcr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [mcr_pkg::PIXEL_BITS-1:0] rsp_pixel_x,
   input logic signed [mcr_pkg::PIXEL_BITS-1:0] rsp_pixel_y,
   input logic rsp_last_point,
   input logic rsp_circle_done
);
   import mcr_pkg::*;

   localparam logic [PT_IDX_BITS-1:0] Y_MIRROR_IDX = PT_IDX_BITS'(1);

   logic                         rsp_acc, rsp_stall, grp_end, grp_mid, mirror_pt;
   logic [2*PIXEL_BITS+1:0]      rsp_word;
   logic [PT_IDX_BITS-1:0]       grp_cnt_ff;
   logic signed [PIXEL_BITS-1:0] prev_x_ff;
   logic                         prev_done_ff;

   assign rsp_acc   = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_pixel_x, rsp_pixel_y, rsp_last_point, rsp_circle_done};
   assign grp_end   = grp_cnt_ff == LAST_POINT_IDX;
   assign grp_mid   = rsp_acc && (grp_cnt_ff != '0);
   assign mirror_pt = rsp_acc && (grp_cnt_ff == Y_MIRROR_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff   <= '0;
         prev_x_ff    <= '0;
         prev_done_ff <= 1'b0;
      end else if (rsp_acc) begin
         grp_cnt_ff   <= grp_cnt_ff + PT_IDX_BITS'(1);
         prev_x_ff    <= rsp_pixel_x;
         prev_done_ff <= rsp_circle_done;
      end
   end

   `MCR_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_word))
   `MCR_ASSERT(a_last_on_eighth, clock, reset, rsp_acc |-> rsp_last_point == grp_end)
   `MCR_ASSERT(a_done_per_group, clock, reset, grp_mid |-> rsp_circle_done == prev_done_ff)
   `MCR_ASSERT(a_y_mirror_same_x, clock, reset, mirror_pt |-> rsp_pixel_x == prev_x_ff)
   `MCR_ASSERT_NR(a_quiet_after_reset, clock, $past(reset) |-> !rsp_valid)

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pixel_x     (rsp_chan.pixel_x),
   .rsp_pixel_y     (rsp_chan.pixel_y),
   .rsp_last_point  (rsp_chan.last_point),
   .rsp_circle_done (rsp_chan.circle_done)
);

`default_nettype wire
